FILE: rtl/core/cbm_pkg.sv
// shared types and constants of the cartridge bank mapper
`default_nettype none

package cbm_pkg;

    localparam int BANK_BYTES  = 4096;
    localparam int XROM_BYTES  = 1024;
    localparam int ADDR_W      = 12;
    localparam int XROM_AW     = 10;
    localparam int BANK_W      = 3;
    localparam int LOAD_W      = 15;

    localparam logic [1:0] CMD_BUS       = 2'd0;
    localparam logic [1:0] CMD_LOAD_ROM  = 2'd1;
    localparam logic [1:0] CMD_LOAD_XROM = 2'd2;

    localparam logic [7:0] BYTE_CHOICE = 8'hfe;
    localparam logic [7:0] BYTE_FLAG   = 8'hff;
    localparam logic [7:0] FLAG_MAGIC  = 8'haa;
    localparam logic [7:0] OP_JMP      = 8'h04;
    localparam logic [7:0] OP_ZERO     = 8'h00;

    localparam logic [BANK_W-1:0] MENU_BANK_TOP = 3'd3;

    typedef enum logic [1:0] {
        MODE_2K4K = 2'd0,
        MODE_8K   = 2'd1,
        MODE_XROM = 2'd2,
        MODE_16K  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
        logic              bank_low_line;
        logic              bank_high_line;
        logic              fetch_strobe_n;
        logic              write_strobe_n;
        logic              chip_select_n;
        logic              inverse_select;
        logic [7:0]        data_in;
        logic [LOAD_W-1:0] load_address;
        logic              reset_pending;
    } cbm_in_t;

    typedef struct packed {
        logic       drive_data;
        logic [7:0] data_out;
        logic       choice_valid;
        logic [7:0] game_choice;
        logic       menu_exit;
    } cbm_out_t;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              bank_ok;
        logic              src_rom;
        logic              src_xrom;
        logic              exit_chk;
        logic              scratch_wr;
        logic              latch_wr;
        logic [BANK_W-1:0] latch_val;
    } cbm_dec_t;

endpackage

`default_nettype wire

FILE: rtl/core/cbm_rom_mem.sv
// banked rom store, one write port and two registered read ports
`default_nettype none

module cbm_rom_mem #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [7:0]    rdata_a,
    output logic      [7:0]    rdata_b
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cbm_xrom_mem.sv
// extra rom store, one write port and one registered read port
`default_nettype none

module cbm_xrom_mem
(
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [cbm_pkg::XROM_AW-1:0] waddr,
    input  wire logic [7:0]            wdata,
    input  wire logic                  re,
    input  wire logic [cbm_pkg::XROM_AW-1:0] raddr,
    output logic      [7:0]            rdata
);

    import cbm_pkg::*;

    logic [7:0] mem [XROM_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cbm_decode.sv
// bus cycle decode: bank select, drive source and side effects of one word
`default_nettype none

module cbm_decode #(
    parameter int NUM_BANKS = 8
) (
    input  wire cbm_pkg::cbm_in_t             word,
    input  wire logic                         in_menu,
    input  wire cbm_pkg::mode_t               game_mode,
    input  wire logic [cbm_pkg::BANK_W-1:0]   bank_latch,
    output cbm_pkg::cbm_dec_t                 dec
);

    import cbm_pkg::*;

    logic [BANK_W-1:0] bank_menu;
    logic              fetch;
    logic              sel_write;

    assign bank_menu = MENU_BANK_TOP - {1'b0, word.bank_high_line, word.bank_low_line};
    assign fetch     = !word.fetch_strobe_n;
    assign sel_write = !word.chip_select_n && !word.write_strobe_n;

    always_comb
    begin
        dec = '0;
        if (word.command == CMD_BUS)
        begin
            if (in_menu)
            begin
                dec.bank       = bank_menu;
                dec.src_rom    = fetch;
                dec.exit_chk   = fetch && word.reset_pending;
                dec.scratch_wr = sel_write && word.inverse_select;
            end
            else
            begin
                unique case (game_mode)
                    MODE_2K4K:
                    begin
                        dec.bank    = word.bank_low_line ? 3'd0 : 3'd1;
                        dec.src_rom = fetch;
                    end
                    MODE_8K:
                    begin
                        dec.bank    = bank_menu;
                        dec.src_rom = fetch;
                    end
                    MODE_XROM:
                    begin
                        if (word.bank_high_line && word.inverse_select)
                        begin
                            dec.src_xrom = 1'b1;
                        end
                        else
                        begin
                            dec.src_rom = fetch;
                        end
                    end
                    MODE_16K:
                    begin
                        if (sel_write)
                        begin
                            dec.latch_wr  = word.address[7];
                            dec.latch_val = ~word.data_in[BANK_W-1:0];
                        end
                        else
                        begin
                            dec.bank    = word.bank_low_line ? 3'd0 : bank_latch;
                            dec.src_rom = fetch;
                        end
                    end
                    default:
                    begin
                        dec.src_rom = 1'b0;
                    end
                endcase
            end
        end
        dec.bank_ok = (32'(dec.bank) < NUM_BANKS);
    end

endmodule

`default_nettype wire

FILE: rtl/core/cartridge_bank_mapper.sv
// top level of the cartridge bank mapper: decode, store reads, result stage
//
// channel   direction  handshake              word
// in        in         in_valid / in_ready    cbm_in_t
// out       out        out_valid / out_ready  cbm_out_t
// cfg       in         cfg_valid / cfg_ready  game_mode, 2 bits
//
// one word per cycle unless stalled: the store read is issued at accept, the
// result is formed from registered read data in the next cycle and held in
// the output register. a menu fetch with a pending reset holds in_ready low
// while the jump to 0 check settles the mode. reset sets the menu flag and
// mode 8K, clears bank latch and both scratch bytes; no clearing pass. a
// stalled output holds the result stage and stops input once it is full.
`default_nettype none

module cartridge_bank_mapper #(
    parameter int NUM_BANKS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cbm_pkg::cbm_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cbm_pkg::cbm_out_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_data
);

    import cbm_pkg::*;

    localparam int ROM_DEPTH = NUM_BANKS * BANK_BYTES;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    logic              in_menu_reg;
    mode_t             game_mode_reg;
    logic [BANK_W-1:0] bank_latch_reg;
    logic [7:0]        byte_choice_reg;
    logic [7:0]        byte_flag_reg;
    logic [7:0]        byte_choice_next;
    logic [7:0]        byte_flag_next;

    logic              s1_valid_reg;
    cbm_dec_t          s1_dec_reg;
    logic [7:0]        s1_din_reg;
    logic [7:0]        s1_low_reg;

    logic              out_valid_reg;
    cbm_out_t          out_reg;
    cbm_out_t          result;

    cbm_dec_t          dec;
    logic              accept;
    logic              s1_adv;
    logic              hazard;
    logic              rom_we;
    logic              xrom_we;
    logic              rd_en;
    logic [ROM_AW-1:0] rom_ra;
    logic [ROM_AW-1:0] rom_rb;
    logic [ADDR_W-1:0] prev_addr;
    logic [7:0]        rd_a;
    logic [7:0]        rd_b;
    logic [7:0]        xrd;
    logic [7:0]        rom_byte;
    logic [7:0]        prev_byte;
    logic              leaving;
    logic              do_scratch;

    cbm_decode #(
        .NUM_BANKS (NUM_BANKS)
    ) u_decode (
        .word       (in_data),
        .in_menu    (in_menu_reg),
        .game_mode  (game_mode_reg),
        .bank_latch (bank_latch_reg),
        .dec        (dec)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign hazard   = s1_valid_reg && s1_dec_reg.exit_chk;
    assign in_ready = !hazard && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign prev_addr = in_data.address - ADDR_W'(1);
    assign rom_ra    = ROM_AW'({dec.bank, in_data.address});
    assign rom_rb    = ROM_AW'({dec.bank, prev_addr});
    assign rd_en     = accept && (in_data.command == CMD_BUS);
    assign rom_we    = accept && (in_data.command == CMD_LOAD_ROM)
                       && (32'(in_data.load_address) < ROM_DEPTH);
    assign xrom_we   = accept && (in_data.command == CMD_LOAD_XROM)
                       && (32'(in_data.load_address) < XROM_BYTES);

    cbm_rom_mem #(
        .DEPTH (ROM_DEPTH),
        .AW    (ROM_AW)
    ) u_rom (
        .clk     (clk),
        .we      (rom_we),
        .waddr   (in_data.load_address[ROM_AW-1:0]),
        .wdata   (in_data.data_in),
        .re      (rd_en),
        .raddr_a (rom_ra),
        .raddr_b (rom_rb),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    cbm_xrom_mem u_xrom (
        .clk   (clk),
        .we    (xrom_we),
        .waddr (in_data.load_address[XROM_AW-1:0]),
        .wdata (in_data.data_in),
        .re    (rd_en),
        .raddr (in_data.address[XROM_AW-1:0]),
        .rdata (xrd)
    );

    always_comb
    begin
        rom_byte  = s1_dec_reg.bank_ok ? rd_a : 8'h00;
        prev_byte = s1_dec_reg.bank_ok ? rd_b : 8'h00;
        leaving   = s1_dec_reg.exit_chk && (rom_byte == OP_ZERO) && (prev_byte == OP_JMP);
        do_scratch = s1_dec_reg.scratch_wr && !leaving;

        byte_choice_next = byte_choice_reg;
        byte_flag_next   = byte_flag_reg;
        if (do_scratch && (s1_low_reg == BYTE_CHOICE))
        begin
            byte_choice_next = s1_din_reg;
        end
        if (do_scratch && (s1_low_reg == BYTE_FLAG))
        begin
            byte_flag_next = s1_din_reg;
        end

        result = '0;
        result.drive_data = s1_dec_reg.src_rom || s1_dec_reg.src_xrom;
        if (s1_dec_reg.src_xrom)
        begin
            result.data_out = xrd;
        end
        else if (s1_dec_reg.src_rom)
        begin
            result.data_out = rom_byte;
        end
        result.menu_exit = leaving;
        if (do_scratch && (byte_flag_next == FLAG_MAGIC))
        begin
            result.choice_valid = 1'b1;
            result.game_choice  = byte_choice_next;
        end
    end

    // mode, latch and scratch bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_menu_reg     <= 1'b1;
            game_mode_reg   <= MODE_8K;
            bank_latch_reg  <= '0;
            byte_choice_reg <= '0;
            byte_flag_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                game_mode_reg <= mode_t'(cfg_data);
            end
            if (accept && dec.latch_wr)
            begin
                bank_latch_reg <= dec.latch_val;
            end
            if (s1_adv)
            begin
                byte_choice_reg <= byte_choice_next;
                byte_flag_reg   <= byte_flag_next;
                if (leaving)
                begin
                    in_menu_reg <= 1'b0;
                end
            end
        end
    end

    // result stage and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dec_reg <= dec;
            s1_din_reg <= in_data.data_in;
            s1_low_reg <= in_data.address[7:0];
        end
        if (s1_adv)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: bench/cartridge_bank_mapper_test.sv
// self-checking bench for the cartridge bank mapper, with a shadow model that predicts each reply
`timescale 1ns / 1ps

module cartridge_bank_mapper_test;
    import cbm_pkg::*;

    localparam int NUM_BANKS      = 8;
    localparam int ROM_SIZE       = NUM_BANKS * BANK_BYTES;
    localparam int LIMIT_CYCLES   = 200_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int SQUEEZE_CYCLES = 250;
    localparam int SHOW_MAX       = 100;
    localparam int MENU_RANDOM    = 300;
    localparam int MODE_RANDOM    = 130;
    localparam int WIN_SIZE       = 16;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [7:0] LATCH_FLOOR = 8'h80;
    localparam logic [ADDR_W-1:0] WIN_HIGH = 12'hff0;
    localparam logic [BANK_W-1:0] EXIT_BANK = 3'd2;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_style_t;

    class mapper_shadow;
        logic [7:0] rom [ROM_SIZE];
        logic [7:0] xrom [XROM_BYTES];
        logic [7:0] scratch [256];
        logic [BANK_W-1:0] latch;
        bit in_menu;
        mode_t mode;
        cbm_out_t replies_due [$];
        int words, matched, mismatches, choices_seen, exits_seen;

        function new();
            foreach (scratch[k]) scratch[k] = 8'h00;
            latch = '0;
            in_menu = 1'b1;
            mode = MODE_8K;
        endfunction

        function void set_mode(logic [1:0] v);
            mode = mode_t'(v);
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction

        function logic [7:0] rom_byte(logic [BANK_W-1:0] bank, logic [ADDR_W-1:0] offs);
            if (bank >= NUM_BANKS)
                return 8'h00;
            return rom[{bank, offs}];
        endfunction

        function string show(cbm_out_t r);
            return $sformatf("drive=%0b data=%02h cv=%0b gc=%02h exit=%0b",
                             r.drive_data, r.data_out, r.choice_valid,
                             r.game_choice, r.menu_exit);
        endfunction

        function void take_word(cbm_in_t w);
            cbm_out_t r;
            logic [BANK_W-1:0] bank;
            logic [ADDR_W-1:0] prev;
            logic [7:0] b;
            bit leaving;
            r = '0;
            leaving = 1'b0;
            prev = w.address - 1'b1;
            bank = MENU_BANK_TOP - {2'b00, w.bank_low_line} - {1'b0, w.bank_high_line, 1'b0};
            words++;
            case (w.command)
                CMD_LOAD_ROM:
                    if (w.load_address < ROM_SIZE)
                        rom[w.load_address] = w.data_in;
                CMD_LOAD_XROM:
                    if (w.load_address < XROM_BYTES)
                        xrom[w.load_address[XROM_AW-1:0]] = w.data_in;
                CMD_BUS:
                    if (in_menu)
                    begin
                        if (!w.fetch_strobe_n)
                        begin
                            b = rom_byte(bank, w.address);
                            r.drive_data = 1'b1;
                            r.data_out = b;
                            if (w.reset_pending && b == OP_ZERO && rom_byte(bank, prev) == OP_JMP)
                            begin
                                leaving = 1'b1;
                                r.menu_exit = 1'b1;
                                in_menu = 1'b0;
                                exits_seen++;
                            end
                        end
                        if (!leaving && !w.chip_select_n && w.inverse_select && !w.write_strobe_n)
                        begin
                            scratch[w.address[7:0]] = w.data_in;
                            if (scratch[BYTE_FLAG] == FLAG_MAGIC)
                            begin
                                r.choice_valid = 1'b1;
                                r.game_choice = scratch[BYTE_CHOICE];
                                choices_seen++;
                            end
                        end
                    end
                    else
                    begin
                        case (mode)
                            MODE_2K4K:
                                if (!w.fetch_strobe_n)
                                begin
                                    r.drive_data = 1'b1;
                                    r.data_out = rom_byte(w.bank_low_line ? 3'd0 : 3'd1, w.address);
                                end
                            MODE_8K:
                                if (!w.fetch_strobe_n)
                                begin
                                    r.drive_data = 1'b1;
                                    r.data_out = rom_byte(bank, w.address);
                                end
                            MODE_XROM:
                                if (w.bank_high_line && w.inverse_select)
                                begin
                                    r.drive_data = 1'b1;
                                    r.data_out = xrom[w.address[XROM_AW-1:0]];
                                end
                                else if (!w.fetch_strobe_n)
                                begin
                                    r.drive_data = 1'b1;
                                    r.data_out = rom_byte(3'd0, w.address);
                                end
                            default:
                                if (!w.chip_select_n && !w.write_strobe_n)
                                begin
                                    if (w.address[7:0] >= LATCH_FLOOR)
                                        latch = ~w.data_in[BANK_W-1:0];
                                end
                                else if (!w.fetch_strobe_n)
                                begin
                                    r.drive_data = 1'b1;
                                    r.data_out = rom_byte(w.bank_low_line ? 3'd0 : latch, w.address);
                                end
                        endcase
                    end
                default: ;
            endcase
            replies_due.push_back(r);
        endfunction

        function void match_reply(cbm_out_t got);
            cbm_out_t want;
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("%0t: reply with none pending: %s", $time, show(got));
                return;
            end
            want = replies_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("%0t: expected %s, got %s", $time, show(want), show(got));
            end
            else
                matched++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    cbm_in_t in_data;
    logic out_valid;
    logic out_ready;
    cbm_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_data;

    mapper_shadow sb = new();
    int cycles = 0;
    int burst_left = 0;
    int squeeze_asked = 0;
    int squeeze_served = 0;
    int modes_written = 0;

    cartridge_bank_mapper #(
        .NUM_BANKS(NUM_BANKS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_mode(cfg_data);
            if (in_valid && in_ready)
                sb.take_word(in_data);
            if (out_valid && out_ready)
                sb.match_reply(out_data);
        end
    end

    // receiver: changing stall styles, plus long hold-offs on request
    initial
    begin : receiver
        int hold_left;
        int style_left;
        int tick;
        rx_style_t style;
        hold_left = 0;
        style_left = 0;
        tick = 0;
        style = RX_OPEN;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (squeeze_asked != squeeze_served)
            begin
                squeeze_served++;
                hold_left = SQUEEZE_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(16, 240);
                end
                style_left--;
                case (style)
                    RX_OPEN:    out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:  out_ready <= ($urandom_range(0, 7) != 0);
                    default:    out_ready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    function automatic cbm_in_t noise_word();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return noise[$bits(cbm_in_t)-1:0];
    endfunction

    function automatic cbm_in_t bus_word(logic [ADDR_W-1:0] addr, logic p10, logic p11,
                                         logic psen_n, logic wr_n, logic cs_n, logic ncs,
                                         logic [7:0] din, logic rpend);
        cbm_in_t w;
        w = noise_word();
        w.command = CMD_BUS;
        w.address = addr;
        w.bank_low_line = p10;
        w.bank_high_line = p11;
        w.fetch_strobe_n = psen_n;
        w.write_strobe_n = wr_n;
        w.chip_select_n = cs_n;
        w.inverse_select = ncs;
        w.data_in = din;
        w.reset_pending = rpend;
        return w;
    endfunction

    function automatic cbm_in_t load_word(logic [1:0] cmd, logic [LOAD_W-1:0] ladr,
                                          logic [7:0] din);
        cbm_in_t w;
        w = noise_word();
        w.command = cmd;
        w.load_address = ladr;
        w.data_in = din;
        return w;
    endfunction

    // offsets that bus words use, around the bank wrap
    function automatic logic [ADDR_W-1:0] window_addr();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom_range(0, WIN_SIZE - 1));
        if ($urandom_range(0, 1) == 0)
            a = a + WIN_HIGH;
        return a;
    endfunction

    // keep the first window byte nonzero and the planted jump to 0 in place
    function automatic cbm_in_t rom_load_word();
        logic [LOAD_W-1:0] ladr;
        logic [7:0] b;
        ladr = LOAD_W'($urandom);
        if ($urandom_range(0, 3) != 0)
            ladr[ADDR_W-1:0] = window_addr();
        b = 8'($urandom);
        if (ladr[ADDR_W-1:0] == WIN_HIGH && b == OP_ZERO)
            b = 8'h01;
        if (ladr[LOAD_W-1:ADDR_W] == EXIT_BANK && ladr[ADDR_W-1:0] == 12'hfff)
            b = OP_JMP;
        if (ladr[LOAD_W-1:ADDR_W] == EXIT_BANK && ladr[ADDR_W-1:0] == 12'h000)
            b = OP_ZERO;
        return load_word(CMD_LOAD_ROM, ladr, b);
    endfunction

    function automatic cbm_in_t random_word();
        cbm_in_t w;
        int pick;
        logic [BANK_W-1:0] bank;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return rom_load_word();
        if (pick < 10)
            return load_word(CMD_LOAD_XROM, LOAD_W'($urandom_range(0, 1279)), 8'($urandom));
        if (pick < 12)
        begin
            w = noise_word();
            w.command = CMD_UNUSED;
            return w;
        end
        w = bus_word(window_addr(), 1'($urandom), 1'($urandom),
                     ($urandom_range(0, 2) == 0), 1'($urandom), ($urandom_range(0, 3) == 0),
                     ($urandom_range(0, 3) != 0), 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 3) == 0)
            w.address = {11'h7ff, 1'($urandom)};
        if ($urandom_range(0, 3) == 0)
            w.data_in = FLAG_MAGIC;
        // keep random fetches from leaving the menu early
        bank = MENU_BANK_TOP - {2'b00, w.bank_low_line} - {1'b0, w.bank_high_line, 1'b0};
        if (w.reset_pending && !w.fetch_strobe_n && sb.rom[{bank, w.address}] == OP_ZERO &&
            sb.rom[{bank, w.address - 1'b1}] == OP_JMP)
            w.reset_pending = 1'b0;
        return w;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input cbm_in_t w);
        int gap;
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic send_random(input int n);
        repeat (n) send_word(random_word());
    endtask

    task automatic write_mode(input mode_t m);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data <= m;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        modes_written++;
    endtask

    initial
    begin : stimulus
        int i;
        int waited;
        logic [7:0] b;
        logic [7:0] prev;
        logic [ADDR_W-1:0] offs;
        logic [BANK_W-1:0] bk;
        mode_t plan [6];
        prev = 8'h00;
        @(posedge rst_n);
        @(negedge clk);
        write_mode(MODE_16K);

        // fill the window of every bank across its wrap: no stray jump to 0,
        // one planted at the wrap of bank 2
        for (i = 0; i < NUM_BANKS * 2 * WIN_SIZE; i++)
        begin
            bk = BANK_W'(i / (2 * WIN_SIZE));
            offs = WIN_HIGH + ADDR_W'(i % (2 * WIN_SIZE));
            b = 8'($urandom);
            if (b == OP_ZERO && (offs == WIN_HIGH || prev == OP_JMP))
                b = 8'h01;
            if (bk == EXIT_BANK && offs == 12'hfff)
                b = OP_JMP;
            if (bk == EXIT_BANK && offs == 12'h000)
                b = OP_ZERO;
            if (bk == 3'd1)
            begin
                case (offs)
                    12'h004: b = 8'h05;
                    12'h005: b = OP_ZERO;
                    12'h007: b = OP_JMP;
                    12'h008: b = 8'h11;
                    default: ;
                endcase
            end
            prev = b;
            send_word(load_word(CMD_LOAD_ROM, {bk, offs}, b));
        end
        for (i = 0; i < 2 * WIN_SIZE; i++)
        begin
            offs = WIN_HIGH + ADDR_W'(i);
            send_word(load_word(CMD_LOAD_XROM, LOAD_W'(offs[XROM_AW-1:0]), 8'($urandom)));
        end

        // menu: one fetch per bank, choice reporting, near misses of the jump to 0
        send_word(bus_word(12'h000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
        send_word(bus_word(12'hfff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'hff, 1'b0));
        send_word(bus_word(12'h004, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
        send_word(bus_word(12'h00a, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
        send_word(bus_word(12'h0fe, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h37, 1'b0));
        send_word(bus_word(12'hfff, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, FLAG_MAGIC, 1'b0));
        send_word(bus_word(12'h3fe, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'hff, 1'b0));
        send_word(bus_word(12'h0ff, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0));
        send_word(bus_word(12'h0ff, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
        send_word(bus_word(12'hfff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1));
        send_word(bus_word(12'h005, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
        send_word(bus_word(12'h008, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
        send_word(bus_word(12'h000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
        send_word(load_word(CMD_UNUSED, LOAD_W'($urandom), 8'($urandom)));
        send_word(load_word(CMD_LOAD_XROM, LOAD_W'(XROM_BYTES), 8'hff));
        send_word(load_word(CMD_LOAD_XROM, '1, 8'h00));
        send_word(load_word(CMD_LOAD_ROM, '1, 8'h5a));

        squeeze_asked++;
        send_random(MENU_RANDOM);

        // jump to 0 across the bank wrap, with a selected write that must be dropped
        write_mode(MODE_2K4K);
        send_word(bus_word(12'h000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, FLAG_MAGIC, 1'b1));

        plan[0] = MODE_2K4K;
        plan[1] = MODE_8K;
        plan[2] = MODE_XROM;
        plan[3] = MODE_16K;
        plan[4] = mode_t'($urandom_range(0, 3));
        plan[5] = mode_t'($urandom_range(0, 3));
        for (i = 0; i < 6; i++)
        begin
            if (i > 0)
                write_mode(plan[i]);
            if (i == 2)
            begin
                squeeze_asked++;
                send_word(bus_word(12'hfff, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0));
                send_word(bus_word(12'h004, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
                send_word(bus_word(12'h004, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0));
            end
            if (i == 3)
            begin
                send_word(bus_word(12'h00b, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
                send_word(bus_word(12'h07f, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
                send_word(bus_word(12'h080, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
                send_word(bus_word(12'hfff, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
                send_word(bus_word(12'h00d, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
                send_word(bus_word(12'hfff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff, 1'b0));
            end
            send_random(MODE_RANDOM);
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.outstanding() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.outstanding() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, sb.outstanding());
            sb.mismatches += sb.outstanding();
        end

        $display("%0d words in, %0d replies matched, %0d mismatches, in %0d cycles",
                 sb.words, sb.matched, sb.mismatches, cycles);
        $display("menu choices %0d, menu exits %0d, mode writes %0d, two long output stalls",
                 sb.choices_seen, sb.exits_seen, modes_written);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
